/* design/mhpq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_pkg
// shared types and constants for the min-heap priority queue
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int CAPACITY_DEF  = 1024;
    localparam int KEY_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_EMPTY      = 2'd2,
        ST_RESERVED   = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic signed [31:0] key_value;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic signed [31:0] min_value;
        logic        min_valid;
        logic [10:0] entry_count;
    } out_beat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_UP_PARK,
        S_DN_LOAD,
        S_DN_HEAD,
        S_DN_LEFT,
        S_DN_CMP,
        S_SR_RD,
        S_SR_CMP,
        S_ROOT_RD,
        S_DONE
    } state_t;

    // memory request from the sequencer
    typedef struct packed {
        logic        rd_en;
        logic        wr_en;
        logic [15:0] rd_addr;
        logic [15:0] wr_addr;
    } mem_req_t;

endpackage
`default_nettype wire

/* design/mhpq_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_store
// heap key store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module mhpq_store
    import mhpq_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
)(
    input  wire logic                 clk,
    input  wire logic                 rd_en,
    input  wire logic [AW-1:0]        rd_addr,
    output logic      [KEY_WIDTH-1:0] rd_data,
    input  wire logic                 wr_en,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire logic [KEY_WIDTH-1:0] wr_data
);

    logic [KEY_WIDTH-1:0] mem [CAPACITY];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

/* design/mhpq_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_ctrl
// command sequencer: sift-up, sift-down and linear search over the store
// ----------------------------------------------------------------------------
module mhpq_ctrl
    import mhpq_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire in_beat_t             in_beat,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output out_beat_t                 out_beat,
    output mem_req_t                  mreq,
    output logic      [KEY_WIDTH-1:0] wr_data,
    input  wire logic [KEY_WIDTH-1:0] rd_data,
    output logic      [CW-1:0]        count_out
);

    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [KEY_WIDTH-1:0] lkey_reg, lkey_next;
    logic [1:0]           status_reg, status_next;
    logic                 found_reg, found_next;
    logic                 ovalid_reg, ovalid_next;
    out_beat_t            obeat_reg, obeat_next;

    logic [AW-1:0]        parent;
    logic [AW:0]          left, right;
    logic [AW:0]          count_w;
    logic [KEY_WIDTH-1:0] ext_key;
    logic [KEY_WIDTH-1:0] min_key;
    logic [AW-1:0]        best;

    assign parent  = AW'((pos_reg - 1'b1) >> 1);
    assign left    = {pos_reg, 1'b1};
    assign right   = left + 1'b1;
    assign count_w = (AW+1)'(count_reg);
    // key field sign-extended or cut to the stored key width
    assign ext_key = KEY_WIDTH'(in_beat.key_value);
    assign in_ready  = (state_reg == S_IDLE) && !ovalid_reg;
    assign out_valid = ovalid_reg;
    assign out_beat  = obeat_reg;
    assign count_out = count_reg;

    // state and data registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        idx_reg    <= idx_next;
        key_reg    <= key_next;
        lkey_reg   <= lkey_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        obeat_reg  <= obeat_next;
    end

    // sequencer: the moving key stays in key_reg and the hole walks the tree
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        idx_next    = idx_reg;
        key_next    = key_reg;
        lkey_next   = lkey_reg;
        status_next = status_reg;
        found_next  = found_reg;
        ovalid_next = ovalid_reg;
        obeat_next  = obeat_reg;
        mreq        = '0;
        wr_data     = key_reg;
        min_key     = lkey_reg;
        best        = AW'(left);
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    status_next = ST_OK;
                    found_next  = 1'b0;
                    key_next    = ext_key;
                    state_next  = S_ROOT_RD;
                    case (in_beat.cmd)
                        CMD_PUSH:
                        begin
                            if (count_reg >= CAP_C)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                // hole at the tail, sift up from there
                                pos_next   = AW'(count_reg);
                                count_next = count_reg + 1'b1;
                                if (count_reg != '0)
                                begin
                                    state_next = S_UP_RD;
                                end
                                else
                                begin
                                    mreq.wr_en   = 1'b1;
                                    mreq.wr_addr = '0;
                                    wr_data      = ext_key;
                                end
                            end
                        end
                        CMD_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                // fetch last entry to move to the root
                                count_next   = count_reg - 1'b1;
                                mreq.rd_en   = 1'b1;
                                mreq.rd_addr = 16'(AW'(count_reg - 1'b1));
                                pos_next     = '0;
                                state_next   = S_DN_LOAD;
                            end
                        end
                        CMD_SEARCH:
                        begin
                            idx_next = '0;
                            if (count_reg != '0)
                            begin
                                state_next = S_SR_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_UP_RD:
            begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = 16'(parent);
                state_next   = S_UP_CMP;
            end
            S_UP_CMP:
            begin
                // key_reg is the moving key, rd_data its parent
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = 16'(pos_reg);
                if ($signed(key_reg) < $signed(rd_data))
                begin
                    // parent moves down into the hole
                    wr_data    = rd_data;
                    pos_next   = parent;
                    state_next = (parent == '0) ? S_UP_PARK : S_UP_RD;
                end
                else
                begin
                    wr_data    = key_reg;
                    state_next = S_ROOT_RD;
                end
            end
            S_UP_PARK:
            begin
                // moving key lands at the root
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = 16'(pos_reg);
                wr_data      = key_reg;
                state_next   = S_ROOT_RD;
            end
            S_DN_LOAD:
            begin
                key_next   = rd_data;
                state_next = S_DN_HEAD;
            end
            S_DN_HEAD:
            begin
                if (left >= count_w)
                begin
                    // no children: park the moving key here
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = 16'(pos_reg);
                    wr_data      = key_reg;
                    state_next   = S_ROOT_RD;
                end
                else
                begin
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = 16'(AW'(left));
                    state_next   = S_DN_LEFT;
                end
            end
            S_DN_LEFT:
            begin
                lkey_next = rd_data;
                if (right < count_w)
                begin
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = 16'(AW'(right));
                    state_next   = S_DN_CMP;
                end
                else
                begin
                    // lone left child: decide now
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = 16'(pos_reg);
                    if ($signed(rd_data) < $signed(key_reg))
                    begin
                        wr_data    = rd_data;
                        pos_next   = AW'(left);
                        state_next = S_DN_HEAD;
                    end
                    else
                    begin
                        wr_data    = key_reg;
                        state_next = S_ROOT_RD;
                    end
                end
            end
            S_DN_CMP:
            begin
                // smaller child, left on a tie
                if ($signed(rd_data) < $signed(lkey_reg))
                begin
                    min_key = rd_data;
                    best    = AW'(right);
                end
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = 16'(pos_reg);
                if ($signed(min_key) < $signed(key_reg))
                begin
                    wr_data    = min_key;
                    pos_next   = best;
                    state_next = S_DN_HEAD;
                end
                else
                begin
                    wr_data    = key_reg;
                    state_next = S_ROOT_RD;
                end
            end
            S_SR_RD:
            begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = 16'(idx_reg);
                state_next   = S_SR_CMP;
            end
            S_SR_CMP:
            begin
                if (rd_data == key_reg)
                begin
                    found_next = 1'b1;
                    state_next = S_ROOT_RD;
                end
                else if ((CW'(idx_reg) + 1'b1) >= count_reg)
                begin
                    state_next = S_ROOT_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SR_RD;
                end
            end
            S_ROOT_RD:
            begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = '0;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                obeat_next.status      = status_reg;
                obeat_next.found       = found_reg;
                obeat_next.min_valid   = (count_reg != '0);
                obeat_next.min_value   = (count_reg != '0) ? 32'(rd_data) : '0;
                obeat_next.entry_count = 11'(count_reg);
                ovalid_next            = 1'b1;
                state_next             = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* design/min_heap_priority_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// min_heap_priority_queue
// bounded binary min-heap with push, pop and search commands
// ----------------------------------------------------------------------------
//  channel   signals                    beat
//  in        in_valid/in_ready/in_data  cmd, key_value
//  out       out_valid/out_ready/out_data status, found, min, count
//
//  a push compares the key with one parent at a time until it is not
//  smaller or reaches the root; a pop compares it with the smaller child
//  level by level until no child is smaller or it sinks to a leaf;
//  a search scans the entries one at a time; the store has one read port
//  reset clears the count; store contents are not cleared
//  a stalled result holds the block until taken
module min_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
)(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_beat_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_beat_t      out_data
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    mem_req_t             mreq;
    logic [KEY_WIDTH-1:0] wr_data, rd_data;
    logic [CW-1:0]        count;

    mhpq_store #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)) u_store (
        .clk     (clk),
        .rd_en   (mreq.rd_en),
        .rd_addr (mreq.rd_addr[AW-1:0]),
        .rd_data (rd_data),
        .wr_en   (mreq.wr_en),
        .wr_addr (mreq.wr_addr[AW-1:0]),
        .wr_data (wr_data)
    );

    mhpq_ctrl #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_beat   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_beat  (out_data),
        .mreq      (mreq),
        .wr_data   (wr_data),
        .rd_data   (rd_data),
        .count_out (count)
    );

    // count never exceeds capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // no new beat accepted while a result waits
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input accepted while result pending");

    // result reports a nonempty heap exactly when count is nonzero
    a_min_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (out_data.min_valid == (count != '0)))
        else $error("min valid disagrees with count");

endmodule
`default_nettype wire

/* test/min_heap_priority_queue_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_priority_queue_test
// drives push, pop, search and no-op commands through the heap with random idling
// on both channels and checks every result against a software heap
// ----------------------------------------------------------------------------
module min_heap_priority_queue_test;
    import mhpq_pkg::*;

    localparam int CAP = 1024;
    localparam longint CYCLE_LIMIT = 64'd5_000_000;

    // software copy of the heap and the results it predicts
    class heap_scoreboard;
        logic signed [31:0] keys [CAP];
        int unsigned count;
        out_beat_t pending [$];
        int errors;
        int n_push, n_pop, n_search, n_full, n_empty, n_found;

        function new();
            count = 0;
            errors = 0;
            n_push = 0; n_pop = 0; n_search = 0;
            n_full = 0; n_empty = 0; n_found = 0;
        endfunction

        function void swap_slots(int unsigned a, int unsigned b);
            logic signed [31:0] t;
            t = keys[a];
            keys[a] = keys[b];
            keys[b] = t;
        endfunction

        // note an accepted input beat and queue its result
        function void note_input(in_beat_t b);
            out_beat_t r;
            int unsigned pos, par, lft, rgt, best;
            bit hit;
            r = '0;
            hit = 0;
            case (b.cmd)
                CMD_PUSH:
                begin
                    n_push++;
                    if (count >= CAP)
                    begin
                        r.status = ST_FULL;
                        n_full++;
                    end
                    else
                    begin
                        keys[count] = b.key_value;
                        pos = count;
                        count++;
                        // sift up while strictly smaller than parent
                        while (pos > 0)
                        begin
                            par = (pos - 1) / 2;
                            if (!(keys[pos] < keys[par])) break;
                            swap_slots(pos, par);
                            pos = par;
                        end
                    end
                end
                CMD_POP:
                begin
                    n_pop++;
                    if (count == 0)
                    begin
                        r.status = ST_EMPTY;
                        n_empty++;
                    end
                    else
                    begin
                        count--;
                        keys[0] = keys[count];
                        pos = 0;
                        // sift down toward the smaller child, left on a tie
                        forever
                        begin
                            lft = 2 * pos + 1;
                            rgt = lft + 1;
                            if (lft >= count) break;
                            best = lft;
                            if (rgt < count && keys[rgt] < keys[lft]) best = rgt;
                            if (!(keys[best] < keys[pos])) break;
                            swap_slots(pos, best);
                            pos = best;
                        end
                    end
                end
                CMD_SEARCH:
                begin
                    n_search++;
                    for (int unsigned i = 0; i < count; i++)
                        if (keys[i] == b.key_value)
                        begin
                            hit = 1;
                            break;
                        end
                    if (hit) n_found++;
                end
                default: ;
            endcase
            if (r.status == 2'd0) r.status = ST_OK;
            r.found = hit;
            r.min_valid = (count > 0);
            r.min_value = (count > 0) ? keys[0] : 32'sd0;
            r.entry_count = count[10:0];
            pending.push_back(r);
        endfunction

        // compare one result beat with the oldest prediction
        function void check_result(out_beat_t a);
            out_beat_t e;
            if (pending.size() == 0)
            begin
                $error("result beat with no prediction waiting: %h", a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.status !== e.status)
            begin
                $error("status: expected %0d actual %0d", e.status, a.status);
                errors++;
            end
            if (a.found !== e.found)
            begin
                $error("found: expected %0d actual %0d", e.found, a.found);
                errors++;
            end
            if (a.min_value !== e.min_value)
            begin
                $error("min_value: expected %0d actual %0d", e.min_value, a.min_value);
                errors++;
            end
            if (a.min_valid !== e.min_valid)
            begin
                $error("min_valid: expected %0d actual %0d", e.min_valid, a.min_valid);
                errors++;
            end
            if (a.entry_count !== e.entry_count)
            begin
                $error("entry_count: expected %0d actual %0d",
                       e.entry_count, a.entry_count);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_beat_t in_data;
    logic out_valid;
    logic out_ready;
    out_beat_t out_data;

    heap_scoreboard board;
    longint cycles;
    int hold_left;
    int recent_keys [$];

    min_heap_priority_queue DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("min_heap_priority_queue_test: FAIL");
            $finish;
        end
    end

    // result side: random stalls, check each accepted beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                board.check_result(out_data);
                hold_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
                if (hold_left > 0) out_ready <= 1'b0;
            end
            else if (!out_ready)
            begin
                if (hold_left > 0) hold_left--;
                if (hold_left == 0) out_ready <= 1'b1;
            end
        end
    end

    // send one command beat after the given gap; valid drops only for a gap
    task automatic send_beat(input logic [1:0] c, input logic signed [31:0] k, input int gap);
        in_beat_t b;
        b.cmd = c;
        b.key_value = k;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= b;
        do @(posedge clk); while (!in_ready);
        board.note_input(b);
        if (c == CMD_PUSH) recent_keys.push_back(k);
        if (recent_keys.size() > 64) void'(recent_keys.pop_front());
    endtask

    function automatic int draw_gap();
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic logic signed [31:0] draw_key();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $signed(32'($urandom_range(0, 40)) - 32'd20);
            default: return $signed($urandom());
        endcase
    endfunction

    initial
    begin
        logic signed [31:0] k;
        int pick, phase_len;
        board = new();
        cycles = 0;
        hold_left = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pop and search, extremes, duplicates, no-op cmd
        send_beat(CMD_POP, 32'sd0, 0);
        send_beat(CMD_SEARCH, 32'sd5, 0);
        send_beat(CMD_NOP, 32'shffff_ffff, 0);
        send_beat(CMD_PUSH, 32'sh7fff_ffff, 0);
        send_beat(CMD_PUSH, 32'sh8000_0000, 1);
        send_beat(CMD_PUSH, 32'sd0, 0);
        send_beat(CMD_PUSH, 32'sd0, 2);
        send_beat(CMD_PUSH, -32'sd1, 0);
        send_beat(CMD_PUSH, 32'sd3, 0);
        send_beat(CMD_SEARCH, 32'sh7fff_ffff, 0);
        send_beat(CMD_SEARCH, 32'sh8000_0000, 0);
        send_beat(CMD_SEARCH, 32'sd42, 3);
        send_beat(CMD_NOP, 32'sd0, 0);
        for (int i = 0; i < 7; i++) send_beat(CMD_POP, $signed($urandom()), 0);
        send_beat(CMD_SEARCH, 32'sd0, 0);

        // random commands; no pushes while the heap holds over 40 entries, so it stays small
        for (int i = 0; i < 630; i++)
        begin
            pick = $urandom_range(0, 99);
            if (board.count > 40) pick = pick / 2 + 50;
            if (pick < 45)
                send_beat(CMD_PUSH, draw_key(), draw_gap());
            else if (pick < 75)
                send_beat(CMD_POP, $signed($urandom()), draw_gap());
            else if (pick < 95)
            begin
                if (recent_keys.size() > 0 && $urandom_range(0, 1))
                    k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
                else
                    k = draw_key();
                send_beat(CMD_SEARCH, k, draw_gap());
            end
            else
                send_beat(CMD_NOP, $signed($urandom()), draw_gap());
        end
        in_valid <= 1'b0;

        // drain and settle
        while (board.pending.size() > 0) @(posedge clk);
        repeat (50) @(posedge clk);
        $display("covered %0d push (%0d full), %0d pop (%0d empty), %0d search (%0d hits)",
                 board.n_push, board.n_full, board.n_pop, board.n_empty,
                 board.n_search, board.n_found);
        if (board.errors == 0)
            $display("min_heap_priority_queue_test: PASS");
        else
            $display("min_heap_priority_queue_test: FAIL");
        $finish;
    end

endmodule
